[rtl/tmes_pkg.sv]
// Shared types, constants and tables of the triangle melody and effect synthesizer.
package tmes_pkg;

   localparam int EFFECT_COUNT_DEF = 6;
   localparam int TABLE_ENTRIES    = 6;

   localparam int ID_W       = 3;
   localparam int CSR_ADDR_W = 2;
   localparam int SAMPLE_W   = 14;
   localparam int PITCH_W    = 11;
   localparam int PHASE_W    = 14;
   localparam int COUNT_W    = 13;
   localparam int STEP_W     = 4;
   localparam int MAG_W      = 12;
   localparam int ENV_W      = 9;
   localparam int BLK_W      = 9;
   localparam int DIV_NUM_W  = 21;
   localparam int DIV_DEN_W  = 13;

   // Triangle oscillator
   localparam logic [PHASE_W-1:0] WAVE_PERIOD = 14'd16000;
   localparam logic [PHASE_W-1:0] WAVE_HALF   = 14'd8000;
   localparam logic [PHASE_W-1:0] TRI_OFFSET  = 14'd4000;

   // Melody timing and envelope
   localparam logic [COUNT_W-1:0]   STEP_LEN    = 13'd6400;
   localparam logic [COUNT_W-1:0]   STEP_LAST   = 13'd6399;
   localparam logic [COUNT_W-1:0]   ATTACK_LEN  = 13'd320;
   localparam logic [COUNT_W-1:0]   DECAY_START = 13'd4800;
   localparam logic [ENV_W-1:0]     ENV_HOLD    = 9'd320;
   localparam logic [DIV_DEN_W-1:0] DECAY_DIV   = 13'd5;
   localparam logic [DIV_DEN_W-1:0] MEL_DIV     = 13'd1600;

   // Effect pitch rules and envelope
   localparam logic [COUNT_W-1:0]   COIN_AFTER     = 13'd1600;
   localparam logic [PITCH_W-1:0]   COIN_PITCH     = 11'd1568;
   localparam logic [PITCH_W-1:0]   EAT_STEP       = 11'd110;
   localparam logic [BLK_W-1:0]     EAT_BLOCK_LAST = 9'd399;
   localparam logic [PITCH_W-1:0]   REST_BASE      = 11'd392;
   localparam logic [DIV_NUM_W-1:0] REST_SPAN      = 21'd130;
   localparam logic [COUNT_W-1:0]   FX_ATTACK      = 13'd80;
   localparam logic [DIV_NUM_W-1:0] ENV_SCALE      = 21'd100;
   localparam logic [DIV_DEN_W-1:0] FX_DIV         = 13'd100;

   typedef enum logic {
      FUNC_RENDER  = 1'b0,
      FUNC_TRIGGER = 1'b1
   } func_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_COIN = 2'd0,
      CSR_EAT  = 2'd1,
      CSR_REST = 2'd2
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MENV,
      ST_MDIV5,
      ST_MTRI,
      ST_MPROD,
      ST_MDIV,
      ST_FX,
      ST_FREST,
      ST_FENV,
      ST_FENVW,
      ST_FTRI,
      ST_FPROD,
      ST_FDIV,
      ST_FEND
   } state_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] dividend;
      logic [DIV_DEN_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic                 done;
      logic [DIV_NUM_W-1:0] quotient;
   } div_rsp_type;

   typedef struct packed {
      logic [PHASE_W-1:0] acc;
      logic [MAG_W-1:0]   mag;
      logic               neg;
   } tri_type;

   function automatic logic [PITCH_W-1:0] melody_note(input logic [STEP_W-1:0] step);
      logic [PITCH_W-1:0] note;
      case (step)
         4'd0:    note = 11'd262;
         4'd1:    note = 11'd330;
         4'd2:    note = 11'd392;
         4'd3:    note = 11'd330;
         4'd4:    note = 11'd294;
         4'd5:    note = 11'd220;
         4'd6:    note = 11'd294;
         4'd7:    note = 11'd349;
         4'd8:    note = 11'd262;
         4'd9:    note = 11'd330;
         4'd10:   note = 11'd440;
         4'd11:   note = 11'd392;
         4'd12:   note = 11'd349;
         4'd13:   note = 11'd294;
         4'd14:   note = 11'd262;
         default: note = 11'd0;
      endcase
      return note;
   endfunction

   function automatic logic [PITCH_W-1:0] fx_pitch(input logic [ID_W-1:0] id);
      logic [PITCH_W-1:0] pitch;
      case (id)
         3'd0:    pitch = 11'd880;
         3'd1:    pitch = 11'd1047;
         3'd2:    pitch = 11'd330;
         3'd3:    pitch = 11'd147;
         3'd4:    pitch = 11'd262;
         3'd5:    pitch = 11'd659;
         default: pitch = 11'd0;
      endcase
      return pitch;
   endfunction

   function automatic logic [COUNT_W-1:0] fx_length(input logic [ID_W-1:0] id);
      logic [COUNT_W-1:0] len;
      case (id)
         3'd0:    len = 13'd640;
         3'd1:    len = 13'd3840;
         3'd2:    len = 13'd2240;
         3'd3:    len = 13'd2880;
         3'd4:    len = 13'd4800;
         3'd5:    len = 13'd960;
         default: len = 13'd1;
      endcase
      return len;
   endfunction

   // One oscillator step: wrap the phase, fold it into a triangle and return
   // the distance from the midline as magnitude and sign.
   function automatic tri_type tri_step(input logic [PHASE_W-1:0] acc,
                                        input logic [PITCH_W-1:0] pitch);
      logic [PHASE_W:0]   p;
      logic [PHASE_W-1:0] w;
      logic [PHASE_W-1:0] v;
      tri_type            res;
      p = {1'b0, acc} + (PHASE_W+1)'(pitch);
      if (p >= {1'b0, WAVE_PERIOD}) begin
         p = p - {1'b0, WAVE_PERIOD};
      end
      w = p[PHASE_W-1:0];
      v = (w < WAVE_HALF) ? w : WAVE_PERIOD - w;
      res.acc = w;
      if (v >= TRI_OFFSET) begin
         res.mag = MAG_W'(v - TRI_OFFSET);
         res.neg = 1'b0;
      end else begin
         res.mag = MAG_W'(TRI_OFFSET - v);
         res.neg = 1'b1;
      end
      return res;
   endfunction

endpackage

[rtl/tmes_if.sv]
// Valid/ready channel interfaces for request and response beats.
interface tmes_req_if;
   import tmes_pkg::*;
   logic            valid;
   logic            ready;
   logic            func;
   logic [ID_W-1:0] effect_id;
   logic            music_on;
   logic            mute;
   modport source(output valid, func, effect_id, music_on, mute, input ready);
   modport sink(input valid, func, effect_id, music_on, mute, output ready);
endinterface

interface tmes_rsp_if;
   import tmes_pkg::*;
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample;
   modport source(output valid, sample, input ready);
   modport sink(input valid, sample, output ready);
endinterface

[rtl/triangle_melody_effect_synth.sv]
// Top level of the triangle melody and sound effect synthesizer.
// A trigger beat is taken and returns nothing. A render beat runs a
// sequencer that shares one bit-serial divider (one quotient bit a clock):
// a muted render runs no division, a render with both the melody and a live
// effect up to five divisions. The next beat is taken once the render has
// placed its sample in the output register; a sample not yet taken holds
// the end of the following render until it leaves.
module triangle_melody_effect_synth #(
   parameter int EFFECT_COUNT = tmes_pkg::EFFECT_COUNT_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [tmes_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [tmes_pkg::ID_W-1:0]     csr_wdata,
   tmes_req_if.sink                      req_ch,
   tmes_rsp_if.source                    rsp_ch
);
   import tmes_pkg::*;

   state_type state_ff, state_in;

   logic [ID_W-1:0] coin_id_ff, eat_id_ff, rest_id_ff;

   logic [STEP_W-1:0]  mel_step_ff, mel_step_in;
   logic [COUNT_W-1:0] mel_t_ff, mel_t_in;
   logic [PHASE_W-1:0] mel_phase_ff, mel_phase_in;

   logic [ID_W-1:0]    fx_id_ff, fx_id_in;
   logic [PHASE_W-1:0] fx_phase_ff, fx_phase_in;
   logic [COUNT_W-1:0] fx_count_ff, fx_count_in;
   logic [BLK_W-1:0]   fx_blk_ff, fx_blk_in;
   logic               fx_odd_ff, fx_odd_in;
   logic               fx_active_ff, fx_active_in;

   logic               music_ff, music_in;
   logic               mute_ff, mute_in;
   logic [ENV_W-1:0]   env_ff, env_in;
   logic [PITCH_W-1:0] pitch_ff, pitch_in;
   logic [MAG_W-1:0]   tri_mag_ff, tri_mag_in;
   logic               tri_neg_ff, tri_neg_in;
   logic signed [SAMPLE_W-1:0] value_ff, value_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] rsp_sample_ff, rsp_sample_in;

   div_req_type div_req;
   div_rsp_type div_rsp;

   logic               req_accept;
   logic               id_ok;
   logic               mel_on;
   logic               mel_decay;
   logic               fx_run;
   logic               fx_rest;
   logic               out_free;
   logic [PITCH_W-1:0] note;
   logic [PITCH_W-1:0] fx_base;
   logic [PITCH_W-1:0] fx_pitch_sel;
   logic [COUNT_W-1:0] fx_len;
   logic [COUNT_W-1:0] fx_count_next;
   logic [COUNT_W-1:0] env_base;
   tri_type            mel_tri;
   tri_type            fx_tri;
   logic [DIV_NUM_W-1:0] mul_prod;
   logic [DIV_NUM_W-1:0] rest_num;
   logic [DIV_NUM_W-1:0] env_num;
   logic signed [SAMPLE_W-1:0] part;

   assign req_accept = req_ch.valid && req_ch.ready;
   assign id_ok = ({1'b0, req_ch.effect_id} < (ID_W+1)'(EFFECT_COUNT))
               && (req_ch.effect_id < ID_W'(TABLE_ENTRIES));
   assign mel_on    = music_ff && !mute_ff;
   assign mel_decay = mel_t_ff > DECAY_START;
   assign fx_run    = fx_active_ff && !mute_ff;
   assign fx_rest   = fx_id_ff == rest_id_ff;
   assign out_free  = !rsp_valid_ff || rsp_ch.ready;

   assign note          = melody_note(mel_step_ff);
   assign fx_base       = fx_pitch(fx_id_ff);
   assign fx_len        = fx_length(fx_id_ff);
   assign fx_count_next = fx_count_ff + 1'b1;
   assign mel_tri       = tri_step(mel_phase_ff, note);
   assign fx_tri        = tri_step(fx_phase_ff, pitch_ff);

   assign mul_prod = DIV_NUM_W'(tri_mag_ff) * DIV_NUM_W'(env_ff);
   assign rest_num = DIV_NUM_W'(fx_count_ff) * REST_SPAN;
   assign env_base = (fx_count_ff < FX_ATTACK) ? fx_count_ff : fx_len - fx_count_ff;
   assign env_num  = DIV_NUM_W'(env_base) * ENV_SCALE;
   assign part     = SAMPLE_W'(div_rsp.quotient);

   always_comb begin
      fx_pitch_sel = fx_base;
      if (fx_id_ff == coin_id_ff && fx_count_ff > COIN_AFTER) begin
         fx_pitch_sel = COIN_PITCH;
      end
      if (fx_id_ff == eat_id_ff && fx_odd_ff) begin
         fx_pitch_sel = fx_pitch_sel + EAT_STEP;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept && req_ch.func == FUNC_RENDER) state_in = ST_MENV;
         end
         ST_MENV: begin
            if (!mel_on) state_in = ST_FX;
            else if (mel_decay) state_in = ST_MDIV5;
            else state_in = ST_MTRI;
         end
         ST_MDIV5: begin
            if (div_rsp.done) state_in = ST_MTRI;
         end
         ST_MTRI: begin
            state_in = (note == '0) ? ST_FX : ST_MPROD;
         end
         ST_MPROD: state_in = ST_MDIV;
         ST_MDIV: begin
            if (div_rsp.done) state_in = ST_FX;
         end
         ST_FX: begin
            if (!fx_run) state_in = ST_FEND;
            else if (fx_rest) state_in = ST_FREST;
            else state_in = ST_FENV;
         end
         ST_FREST: begin
            if (div_rsp.done) state_in = ST_FENV;
         end
         ST_FENV: state_in = ST_FENVW;
         ST_FENVW: begin
            if (div_rsp.done) state_in = ST_FTRI;
         end
         ST_FTRI:  state_in = ST_FPROD;
         ST_FPROD: state_in = ST_FDIV;
         ST_FDIV: begin
            if (div_rsp.done) state_in = ST_FEND;
         end
         ST_FEND: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and outputs
   always_comb begin
      mel_step_in   = mel_step_ff;
      mel_t_in      = mel_t_ff;
      mel_phase_in  = mel_phase_ff;
      fx_id_in      = fx_id_ff;
      fx_phase_in   = fx_phase_ff;
      fx_count_in   = fx_count_ff;
      fx_blk_in     = fx_blk_ff;
      fx_odd_in     = fx_odd_ff;
      fx_active_in  = fx_active_ff;
      music_in      = music_ff;
      mute_in       = mute_ff;
      env_in        = env_ff;
      pitch_in      = pitch_ff;
      tri_mag_in    = tri_mag_ff;
      tri_neg_in    = tri_neg_ff;
      value_in      = value_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_sample_in = rsp_sample_ff;
      div_req       = '0;

      if (rsp_valid_ff && rsp_ch.ready) rsp_valid_in = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_ch.func == FUNC_TRIGGER) begin
                  if (id_ok) begin
                     fx_id_in     = req_ch.effect_id;
                     fx_phase_in  = '0;
                     fx_count_in  = '0;
                     fx_blk_in    = '0;
                     fx_odd_in    = 1'b0;
                     fx_active_in = 1'b1;
                  end
               end else begin
                  music_in = req_ch.music_on;
                  mute_in  = req_ch.mute;
                  value_in = '0;
               end
            end
         end
         ST_MENV: begin
            if (mel_t_ff < ATTACK_LEN) begin
               env_in = ENV_W'(mel_t_ff);
            end else if (mel_decay) begin
               div_req.start    = mel_on;
               div_req.dividend = DIV_NUM_W'(STEP_LEN - mel_t_ff);
               div_req.divisor  = DECAY_DIV;
            end else begin
               env_in = ENV_HOLD;
            end
         end
         ST_MDIV5: begin
            if (div_rsp.done) env_in = ENV_W'(div_rsp.quotient);
         end
         ST_MTRI: begin
            // The melody clock moves on even over the silent last step.
            if (mel_t_ff == STEP_LAST) begin
               mel_t_in    = '0;
               mel_step_in = mel_step_ff + 1'b1;
            end else begin
               mel_t_in = mel_t_ff + 1'b1;
            end
            if (note != '0) begin
               mel_phase_in = mel_tri.acc;
               tri_mag_in   = mel_tri.mag;
               tri_neg_in   = mel_tri.neg;
            end
         end
         ST_MPROD: begin
            div_req.start    = 1'b1;
            div_req.dividend = mul_prod;
            div_req.divisor  = MEL_DIV;
         end
         ST_MDIV: begin
            if (div_rsp.done) value_in = tri_neg_ff ? value_ff - part : value_ff + part;
         end
         ST_FX: begin
            pitch_in = fx_pitch_sel;
            if (fx_run && fx_rest) begin
               div_req.start    = 1'b1;
               div_req.dividend = rest_num;
               div_req.divisor  = fx_len;
            end
         end
         ST_FREST: begin
            if (div_rsp.done) pitch_in = REST_BASE - PITCH_W'(div_rsp.quotient);
         end
         ST_FENV: begin
            div_req.start    = 1'b1;
            div_req.dividend = env_num;
            div_req.divisor  = (fx_count_ff < FX_ATTACK) ? FX_ATTACK : fx_len;
         end
         ST_FENVW: begin
            if (div_rsp.done) env_in = ENV_W'(div_rsp.quotient);
         end
         ST_FTRI: begin
            fx_phase_in = fx_tri.acc;
            tri_mag_in  = fx_tri.mag;
            tri_neg_in  = fx_tri.neg;
         end
         ST_FPROD: begin
            div_req.start    = 1'b1;
            div_req.dividend = mul_prod;
            div_req.divisor  = FX_DIV;
         end
         ST_FDIV: begin
            if (div_rsp.done) value_in = tri_neg_ff ? value_ff - part : value_ff + part;
         end
         ST_FEND: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_sample_in = value_ff;
               if (fx_active_ff) begin
                  fx_count_in = fx_count_next;
                  if (fx_blk_ff == EAT_BLOCK_LAST) begin
                     fx_blk_in = '0;
                     fx_odd_in = !fx_odd_ff;
                  end else begin
                     fx_blk_in = fx_blk_ff + 1'b1;
                  end
                  if (fx_count_next >= fx_len) fx_active_in = 1'b0;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         coin_id_ff   <= 3'd1;
         eat_id_ff    <= 3'd0;
         rest_id_ff   <= 3'd4;
         mel_step_ff  <= '0;
         mel_t_ff     <= '0;
         mel_phase_ff <= '0;
         fx_id_ff     <= '0;
         fx_phase_ff  <= '0;
         fx_count_ff  <= '0;
         fx_blk_ff    <= '0;
         fx_odd_ff    <= 1'b0;
         fx_active_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mel_step_ff  <= mel_step_in;
         mel_t_ff     <= mel_t_in;
         mel_phase_ff <= mel_phase_in;
         fx_id_ff     <= fx_id_in;
         fx_phase_ff  <= fx_phase_in;
         fx_count_ff  <= fx_count_in;
         fx_blk_ff    <= fx_blk_in;
         fx_odd_ff    <= fx_odd_in;
         fx_active_ff <= fx_active_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_addr)
               CSR_COIN: coin_id_ff <= csr_wdata;
               CSR_EAT:  eat_id_ff  <= csr_wdata;
               CSR_REST: rest_id_ff <= csr_wdata;
               default:  ;
            endcase
         end
      end
      music_ff      <= music_in;
      mute_ff       <= mute_in;
      env_ff        <= env_in;
      pitch_ff      <= pitch_in;
      tri_mag_ff    <= tri_mag_in;
      tri_neg_ff    <= tri_neg_in;
      value_ff      <= value_in;
      rsp_sample_ff <= rsp_sample_in;
   end

   assign req_ch.ready  = (state_ff == ST_IDLE);
   assign rsp_ch.valid  = rsp_valid_ff;
   assign rsp_ch.sample = rsp_sample_ff;

   tmes_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

endmodule

[rtl/tmes_div.sv]
// Bit-serial restoring divider, one quotient bit per clock.
module tmes_div (
   input  logic                  clock,
   input  logic                  reset,
   input  tmes_pkg::div_req_type req,
   output tmes_pkg::div_rsp_type rsp
);
   import tmes_pkg::*;

   localparam int CNT_W = $clog2(DIV_NUM_W);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [DIV_NUM_W-1:0] quot_ff, quot_in;
   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [DIV_DEN_W:0]   shifted;
   logic [DIV_DEN_W:0]   diff;
   logic                 ge;

   assign shifted = {rem_ff, quot_ff[DIV_NUM_W-1]};
   assign diff    = shifted - {1'b0, den_ff};
   assign ge      = shifted >= {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quot_in = quot_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quot_in = req.dividend;
         rem_in  = '0;
         den_in  = req.divisor;
      end else if (busy_ff) begin
         quot_in = {quot_ff[DIV_NUM_W-2:0], ge};
         rem_in  = ge ? diff[DIV_DEN_W-1:0] : shifted[DIV_DEN_W-1:0];
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DIV_NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quot_ff;

endmodule

[rtl/tmes_checker.sv]
// Port-level checks for the synthesizer and their attachment to the top level.
module tmes_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic                               req_func,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic signed [tmes_pkg::SAMPLE_W-1:0] rsp_sample
);
   import tmes_pkg::*;

   // A result beat waits until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result beat dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_sample))
      else $error("result sample changed while stalled");

   // A render keeps the sequencer busy; a trigger leaves the request channel ready.
   a_render_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_func == FUNC_RENDER |=> !req_ready)
      else $error("request taken again right after a render");

   a_trigger_ready: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_func == FUNC_TRIGGER |=> req_ready)
      else $error("trigger stalled the request channel");

   // Melody and effect together never leave this range.
   a_sample_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_sample >= -4800 && rsp_sample <= 4800)
      else $error("result sample out of mixing range");

endmodule

bind triangle_melody_effect_synth tmes_checker u_tmes_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_ch.valid),
   .req_ready  (req_ch.ready),
   .req_func   (req_ch.func),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .rsp_sample (rsp_ch.sample)
);
